>>> src/rdi_pkg.sv
// shared constants and types for the ray / disk intersection core
package rdi_pkg;

	localparam int ADDR_W = 5;
	localparam int DEN_W  = 52;
	localparam int NUM_W  = 54;
	localparam int DU_W   = 51;
	localparam int QB     = 33;
	localparam int NQ_W   = 70;

	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_Z = 3'd2;
	localparam logic [2:0] REG_RADIUS   = 3'd3;
	localparam logic [2:0] REG_NORMAL_X = 3'd4;
	localparam logic [2:0] REG_NORMAL_Y = 3'd5;
	localparam logic [2:0] REG_NORMAL_Z = 3'd6;
	localparam logic [2:0] REG_TOL      = 3'd7;

	typedef struct packed {
		logic [2:0][31:0] cen;
		logic [30:0]      radius;
		logic [2:0][17:0] nrm;
		logic [15:0]      tol;
		logic [61:0]      rsq;
	} rdi_cfg_t;

	typedef struct packed {
		logic [2:0][32:0] ocd;
		logic [2:0][31:0] dir;
		logic [31:0]      tmin;
		logic [31:0]      tmax;
		logic             neg;
		logic             ok;
	} rdi_side_t;

endpackage

>>> src/rdi_if.sv
// request channels for rays and results
interface rdi_ray_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [31:0] origin_z;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;
	logic signed [31:0] t_min;
	logic signed [31:0] t_max;
	modport source(output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		t_min, t_max, input ready);
	modport sink(input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		t_min, t_max, output ready);
endinterface

interface rdi_res_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] t_hit;
	modport source(output valid, hit, t_hit, input ready);
	modport sink(input valid, hit, t_hit, output ready);
endinterface

>>> src/ray_disk_intersect_core.sv
// top level of the ray / disk intersection core
// One ray enters per clock and one result (hit flag and Q16.16 distance, zero
// on a miss) leaves per clock while res.ready is high. Three front stages form
// the dot products and the dividend, the divider spends one stage on the range
// check plus one stage per quotient bit (33 bits), and four back stages
// rebuild the hit point and test it against the radius. Results land in a
// two-entry output buffer, so the pipeline keeps taking rays while a result
// waits; it stalls only when that buffer is full and a result is ready to
// enter it. The user must set the disk through the apb port while no ray is
// in flight (not enforced); the squared radius is registered from the radius.
module ray_disk_intersect_core (
	input  logic                       clk,
	input  logic                       arst_n,
	rdi_ray_if.sink                    ray,
	rdi_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rdi_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	localparam int DEN_W = rdi_pkg::DEN_W;
	localparam int NUM_W = rdi_pkg::NUM_W;
	localparam int DU_W  = rdi_pkg::DU_W;
	localparam int QB    = rdi_pkg::QB;
	localparam int NQ_W  = rdi_pkg::NQ_W;

	rdi_pkg::rdi_cfg_t cfg;

	rdi_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// global advance: everything moves unless the last stage is blocked
	logic en;
	logic v1_s1, v2_s2, v3_s3, vd, v4_s4, v5_s5, v6_s6, v7_s7;
	logic [1:0] cnt_q;

	assign en        = ~v7_s7 | (cnt_q != 2'd2);
	assign ray.ready = en;

	// stage 1: the six products of the two dot products
	logic signed [31:0] org [3];
	logic signed [31:0] dir [3];
	logic signed [18:0] nneg [3];
	logic signed [32:0] cmo [3];
	logic signed [50:0] pden_c [3];
	logic signed [51:0] pnum_c [3];
	rdi_pkg::rdi_side_t side_c1;

	assign org[0] = ray.origin_x;
	assign org[1] = ray.origin_y;
	assign org[2] = ray.origin_z;
	assign dir[0] = ray.dir_x;
	assign dir[1] = ray.dir_y;
	assign dir[2] = ray.dir_z;

	always_comb begin
		side_c1      = '0;
		side_c1.tmin = ray.t_min;
		side_c1.tmax = ray.t_max;
		for (int i = 0; i < 3; i++) begin
			nneg[i]   = -$signed({cfg.nrm[i][17], cfg.nrm[i]});
			cmo[i]    = $signed({cfg.cen[i][31], cfg.cen[i]}) - $signed({org[i][31], org[i]});
			pden_c[i] = nneg[i] * dir[i];
			pnum_c[i] = cmo[i] * nneg[i];
			side_c1.ocd[i] = -cmo[i];
			side_c1.dir[i] = dir[i];
		end
	end

	logic signed [50:0] pden_s1 [3];
	logic signed [51:0] pnum_s1 [3];
	rdi_pkg::rdi_side_t side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pden_s1 <= pden_c;
			pnum_s1 <= pnum_c;
			side_s1 <= side_c1;
		end
	end

	// stage 2: sums and the facing test
	logic signed [DEN_W-1:0] den_c, thr;
	logic signed [NUM_W-1:0] num_c;
	rdi_pkg::rdi_side_t side_c2;

	always_comb begin
		den_c      = pden_s1[0] + pden_s1[1] + pden_s1[2];
		num_c      = pnum_s1[0] + pnum_s1[1] + pnum_s1[2];
		thr        = DEN_W'({cfg.tol, 16'd0});
		side_c2    = side_s1;
		side_c2.ok = den_c > thr;
	end

	logic signed [DEN_W-1:0] den_s2;
	logic signed [NUM_W-1:0] num_s2;
	rdi_pkg::rdi_side_t side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s2  <= den_c;
			num_s2  <= num_c;
			side_s2 <= side_c2;
		end
	end

	// stage 3: dividend for a floor quotient; negative num uses -(|num|+den-1)/den
	logic [NUM_W-1:0] mag_c;
	logic [NQ_W-1:0]  nq_c;
	rdi_pkg::rdi_side_t side_c3;

	always_comb begin
		side_c3     = side_s2;
		side_c3.neg = num_s2[NUM_W-1];
		mag_c       = side_c3.neg ? NUM_W'(-num_s2) : NUM_W'(num_s2);
		nq_c        = {mag_c, 16'd0};
		if (side_c3.neg) begin
			nq_c = nq_c + NQ_W'(den_s2[DU_W-1:0]) - NQ_W'(1);
		end
	end

	logic [NQ_W-1:0] nq_s3;
	logic [DU_W-1:0] dd_s3;
	rdi_pkg::rdi_side_t side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			nq_s3   <= nq_c;
			dd_s3   <= den_s2[DU_W-1:0];
			side_s3 <= side_c3;
		end
	end

	logic [QB-1:0] quo_d;
	rdi_pkg::rdi_side_t side_d;

	rdi_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (v3_s3),
		.nq      (nq_s3),
		.den     (dd_s3),
		.side_in (side_s3),
		.out_vld (vd),
		.quo     (quo_d),
		.side_out(side_d)
	);

	// stage 4: signed distance, 32-bit range and interval test
	logic [QB:0]  tf_c;
	logic [31:0]  t_c;
	logic         inr_c, ok4_c;

	always_comb begin
		tf_c  = side_d.neg ? -{1'b0, quo_d} : {1'b0, quo_d};
		t_c   = tf_c[31:0];
		inr_c = side_d.neg ? (quo_d <= 33'h0_8000_0000) : (quo_d[32:31] == 2'b00);
		ok4_c = side_d.ok & inr_c & ($signed(t_c) >= $signed(side_d.tmin))
			& ($signed(t_c) <= $signed(side_d.tmax));
	end

	logic [31:0]      t_s4;
	logic             ok_s4;
	logic [2:0][32:0] ocd_s4;
	logic [2:0][31:0] dir_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4   <= t_c;
			ok_s4  <= ok4_c;
			ocd_s4 <= side_d.ocd;
			dir_s4 <= side_d.dir;
		end
	end

	// stage 5: t times direction
	logic signed [63:0] p_s5 [3];
	logic [2:0][32:0]   ocd_s5;
	logic [31:0]        t_s5;
	logic               ok_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s5[i] <= $signed(t_s4) * $signed(dir_s4[i]);
			end
			ocd_s5 <= ocd_s4;
			t_s5   <= t_s4;
			ok_s5  <= ok_s4;
		end
	end

	// stage 6: hit point offset, magnitude truncated to Q16.16
	logic [64:0] off_c [3];
	logic [64:0] omag_c [3];
	logic [30:0] d_c [3];
	logic        big_c;

	always_comb begin
		big_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			off_c[i]  = {{16{ocd_s5[i][32]}}, ocd_s5[i], 16'd0} + {p_s5[i][63], p_s5[i]};
			omag_c[i] = off_c[i][64] ? -off_c[i] : off_c[i];
			big_c     = big_c | (omag_c[i][64:16] > {18'd0, cfg.radius});
			d_c[i]    = omag_c[i][46:16];
		end
	end

	logic [30:0] d_s6 [3];
	logic        big_s6, ok_s6;
	logic [31:0] t_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s6   <= d_c;
			big_s6 <= big_c;
			ok_s6  <= ok_s5;
			t_s6   <= t_s5;
		end
	end

	// stage 7: squares
	logic [61:0] sq_s7 [3];
	logic        ok_s7;
	logic [31:0] t_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= 62'(d_s6[i]) * 62'(d_s6[i]);
			end
			ok_s7 <= ok_s6 & ~big_s6;
			t_s7  <= t_s6;
		end
	end

	// radius test feeds the output buffer directly
	logic [63:0] acc_c;
	logic        hit_c;
	logic [31:0] th_c;

	always_comb begin
		acc_c = 64'(sq_s7[0]) + 64'(sq_s7[1]) + 64'(sq_s7[2]);
		hit_c = ok_s7 & (acc_c <= 64'(cfg.rsq));
		th_c  = hit_c ? t_s7 : 32'd0;
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
			v7_s7 <= 1'b0;
		end else if (en) begin
			v1_s1 <= ray.valid;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= vd;
			v5_s5 <= v4_s4;
			v6_s6 <= v5_s5;
			v7_s7 <= v6_s6;
		end
	end

	// two-entry output buffer, entry 0 is the head
	logic        push, pop, wr_hi;
	logic        ent_hit_q [2];
	logic [31:0] ent_t_q   [2];

	assign push  = v7_s7 & en;
	assign pop   = res.valid & res.ready;
	assign wr_hi = (cnt_q == 2'd2) | ((cnt_q == 2'd1) & ~pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// a new result into the head wins over the shift from entry 1
	always_ff @(posedge clk) begin
		if (push && !wr_hi) begin
			ent_hit_q[0] <= hit_c;
			ent_t_q[0]   <= th_c;
		end else if (pop) begin
			ent_hit_q[0] <= ent_hit_q[1];
			ent_t_q[0]   <= ent_t_q[1];
		end
		if (push && wr_hi) begin
			ent_hit_q[1] <= hit_c;
			ent_t_q[1]   <= th_c;
		end
	end

	assign res.valid = cnt_q != 2'd0;
	assign res.hit   = ent_hit_q[0];
	assign res.t_hit = ent_t_q[0];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer overfilled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.hit) |-> (res.t_hit == 32'd0))
		else $error("miss carries a nonzero distance");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !res.ready) |=> (cnt_q == 2'd2))
		else $error("buffered result lost while stalled");

	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(v7_s7 && !en) |=> v7_s7)
		else $error("last stage dropped a request while stalled");
endmodule

>>> src/rdi_cfg.sv
// apb register file holding the disk description
module rdi_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [rdi_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output rdi_pkg::rdi_cfg_t         cfg
);
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[rdi_pkg::ADDR_W-1:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.cen    <= '0;
			cfg.radius <= 31'd65536;
			cfg.nrm    <= {18'd65536, 18'd0, 18'd0};
			cfg.tol    <= 16'd1;
			cfg.rsq    <= 62'h1_0000_0000;
		end else begin
			// squared radius follows the radius in the next cycle
			cfg.rsq <= 62'(cfg.radius) * 62'(cfg.radius);
			if (wr) begin
				unique case (idx)
					rdi_pkg::REG_CENTER_X: cfg.cen[0] <= pwdata;
					rdi_pkg::REG_CENTER_Y: cfg.cen[1] <= pwdata;
					rdi_pkg::REG_CENTER_Z: cfg.cen[2] <= pwdata;
					rdi_pkg::REG_RADIUS:   cfg.radius <= pwdata[30:0];
					rdi_pkg::REG_NORMAL_X: cfg.nrm[0] <= pwdata[17:0];
					rdi_pkg::REG_NORMAL_Y: cfg.nrm[1] <= pwdata[17:0];
					rdi_pkg::REG_NORMAL_Z: cfg.nrm[2] <= pwdata[17:0];
					rdi_pkg::REG_TOL:      cfg.tol <= pwdata[15:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (idx)
			rdi_pkg::REG_CENTER_X: prdata = cfg.cen[0];
			rdi_pkg::REG_CENTER_Y: prdata = cfg.cen[1];
			rdi_pkg::REG_CENTER_Z: prdata = cfg.cen[2];
			rdi_pkg::REG_RADIUS:   prdata = {1'b0, cfg.radius};
			rdi_pkg::REG_NORMAL_X: prdata = {14'd0, cfg.nrm[0]};
			rdi_pkg::REG_NORMAL_Y: prdata = {14'd0, cfg.nrm[1]};
			rdi_pkg::REG_NORMAL_Z: prdata = {14'd0, cfg.nrm[2]};
			rdi_pkg::REG_TOL:      prdata = {16'd0, cfg.tol};
			default:               prdata = '0;
		endcase
	end
endmodule

>>> src/rdi_div.sv
// pipelined restoring divider, one quotient bit per stage
module rdi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [rdi_pkg::NQ_W-1:0]   nq,
	input  logic [rdi_pkg::DU_W-1:0]   den,
	input  rdi_pkg::rdi_side_t         side_in,
	output logic                       out_vld,
	output logic [rdi_pkg::QB-1:0]     quo,
	output rdi_pkg::rdi_side_t         side_out
);
	localparam int QB   = rdi_pkg::QB;
	localparam int DU_W = rdi_pkg::DU_W;
	localparam int NQ_W = rdi_pkg::NQ_W;

	logic              vld_s  [0:QB];
	logic [DU_W-1:0]   rem_s  [0:QB];
	logic [DU_W-1:0]   den_s  [0:QB];
	logic [QB-1:0]     low_s  [0:QB];
	logic [QB-1:0]     quo_s  [0:QB];
	rdi_pkg::rdi_side_t side_s [0:QB];
	rdi_pkg::rdi_side_t side_c;

	// quotient must fit in QB bits: high part of the dividend below den
	always_comb begin
		side_c    = side_in;
		side_c.ok = side_in.ok & (DU_W'(nq[NQ_W-1:QB]) < den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= DU_W'(nq[NQ_W-1:QB]);
			low_s[0]  <= nq[QB-1:0];
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			side_s[0] <= side_c;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DU_W:0] shf;
		logic [DU_W:0] dif;
		logic          ge;

		always_comb begin
			shf = {rem_s[k], low_s[k][QB-1]};
			dif = shf - {1'b0, den_s[k]};
			ge  = ~dif[DU_W];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? dif[DU_W-1:0] : shf[DU_W-1:0];
				low_s[k+1]  <= {low_s[k][QB-2:0], 1'b0};
				den_s[k+1]  <= den_s[k];
				quo_s[k+1]  <= {quo_s[k][QB-2:0], ge};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[QB];
	assign quo      = quo_s[QB];
	assign side_out = side_s[QB];
endmodule

>>> test/rdi_disk_checker.sv
`timescale 1ns / 1ps
// checker for the ray / disk core: follows the disk registers, predicts each result, compares
module rdi_disk_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	rdi_ray_if                         ray,
	rdi_res_if                         res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [rdi_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output int                         fails,
	output int                         pending
);

	typedef struct {
		logic        hit;
		logic [31:0] t_hit;
	} disk_result_t;

	disk_result_t       hits_q[$];
	logic signed [31:0] cen[3];
	logic [30:0]        radius;
	logic signed [17:0] nrm[3];
	logic [15:0]        tol;

	function automatic disk_result_t trace_disk(
		input logic signed [31:0] ox, oy, oz, dx, dy, dz, tlo, thi);
		longint          o[3], d[3], c[3], nv[3];
		longint          den, num, q, r, t, off;
		longint unsigned frac, acc, dm, rad;
		disk_result_t    rv;
		bit              inside_r;
		rv.hit = 1'b0;
		rv.t_hit = '0;
		o[0] = ox; o[1] = oy; o[2] = oz;
		d[0] = dx; d[1] = dy; d[2] = dz;
		for (int i = 0; i < 3; i++) begin
			c[i] = cen[i];
			nv[i] = -longint'(nrm[i]);
		end
		den = 0;
		for (int i = 0; i < 3; i++) den += nv[i] * d[i];
		if (den <= longint'(tol) * 65536) return rv;
		num = 0;
		for (int i = 0; i < 3; i++) num += (c[i] - o[i]) * nv[i];
		// floor division, den is positive here
		q = num / den;
		r = num % den;
		if (r < 0) begin
			q -= 1;
			r += den;
		end
		if (q >= 32768 || q < -32768) return rv;
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			r = r * 2;
			frac = frac << 1;
			if (r >= den) begin
				r -= den;
				frac |= 1;
			end
		end
		t = q * 65536 + longint'(frac);
		if (t < longint'(tlo) || t > longint'(thi)) return rv;
		rad = radius;
		acc = 0;
		inside_r = 1'b1;
		for (int i = 0; i < 3; i++) begin
			off = (o[i] - c[i]) * 65536 + t * d[i];
			dm = (off < 0) ? $unsigned(-off) : $unsigned(off);
			dm = dm >> 16;
			if (dm > rad) inside_r = 1'b0;
			else acc += dm * dm;
		end
		if (inside_r && acc <= rad * rad) begin
			rv.hit = 1'b1;
			rv.t_hit = t[31:0];
		end
		return rv;
	endfunction

	task automatic report_mismatch(input string msg);
		fails++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		disk_result_t want;
		if (!arst_n) begin
			fails = 0;
			cen[0] <= '0; cen[1] <= '0; cen[2] <= '0;
			radius <= 31'd65536;
			nrm[0] <= '0; nrm[1] <= '0; nrm[2] <= 18'sd65536;
			tol <= 16'd1;
			hits_q.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					rdi_pkg::REG_CENTER_X: cen[0] <= pwdata;
					rdi_pkg::REG_CENTER_Y: cen[1] <= pwdata;
					rdi_pkg::REG_CENTER_Z: cen[2] <= pwdata;
					rdi_pkg::REG_RADIUS:   radius <= pwdata[30:0];
					rdi_pkg::REG_NORMAL_X: nrm[0] <= pwdata[17:0];
					rdi_pkg::REG_NORMAL_Y: nrm[1] <= pwdata[17:0];
					rdi_pkg::REG_NORMAL_Z: nrm[2] <= pwdata[17:0];
					rdi_pkg::REG_TOL:      tol <= pwdata[15:0];
					default: ;
				endcase
			end
			if (ray.valid && ray.ready)
				hits_q.push_back(trace_disk(ray.origin_x, ray.origin_y, ray.origin_z,
					ray.dir_x, ray.dir_y, ray.dir_z, ray.t_min, ray.t_max));
			if (res.valid && res.ready) begin
				if (hits_q.size() == 0) begin
					report_mismatch("result with no ray outstanding");
				end else begin
					want = hits_q.pop_front();
					if (res.hit !== want.hit)
						report_mismatch($sformatf("hit %b, want %b", res.hit, want.hit));
					if (res.t_hit !== want.t_hit)
						report_mismatch($sformatf("t_hit %h, want %h", res.t_hit, want.t_hit));
				end
			end
			pending <= hits_q.size();
		end
	end

endmodule

>>> test/tb_ray_disk_intersect_core.sv
`timescale 1ns / 1ps
// testbench top: clock, reset, disk setup over apb, ray stimulus and verdict
module tb_ray_disk_intersect_core;

	localparam int ONE = 65536;

	logic                       clk;
	logic                       arst_n;
	logic                       psel, penable, pwrite;
	logic [rdi_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;
	int                         fails, pending;

	// calm turns off idling on both sides
	bit calm;

	// stimulus copy of the disk, used only to aim rays
	int disk_c[3];
	int disk_r;
	int disk_n[3];

	rdi_ray_if ray ();
	rdi_res_if res ();

	ray_disk_intersect_core dut (
		.clk(clk), .arst_n(arst_n), .ray(ray), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	rdi_disk_checker chk (
		.clk(clk), .arst_n(arst_n), .ray(ray), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous cap on the whole run
	initial begin
		#3ms;
		$display("CHECK FAILED");
		$finish;
	end

	// result side stalls at random unless calm
	always @(posedge clk) res.ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);

	// one apb write: setup cycle, then access cycle
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// wait until the pipe is empty, then let the latency run out
	task automatic drain();
		ray.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_disk(input int cx, cy, cz, r, nx, ny, nz, tl);
		drain();
		reg_write(rdi_pkg::REG_CENTER_X, cx);
		reg_write(rdi_pkg::REG_CENTER_Y, cy);
		reg_write(rdi_pkg::REG_CENTER_Z, cz);
		reg_write(rdi_pkg::REG_RADIUS, r);
		reg_write(rdi_pkg::REG_NORMAL_X, nx);
		reg_write(rdi_pkg::REG_NORMAL_Y, ny);
		reg_write(rdi_pkg::REG_NORMAL_Z, nz);
		reg_write(rdi_pkg::REG_TOL, tl);
		// squared radius settles in the cycle after the radius write
		repeat (3) @(posedge clk);
		disk_c[0] = cx; disk_c[1] = cy; disk_c[2] = cz;
		disk_r = r & 32'h7fffffff;
		disk_n[0] = int'(signed'(nx[17:0]));
		disk_n[1] = int'(signed'(ny[17:0]));
		disk_n[2] = int'(signed'(nz[17:0]));
	endtask

	// present one request and hold it until taken
	task automatic send_ray(input int ox, oy, oz, dx, dy, dz, tlo, thi);
		while (!calm && $urandom_range(99) < 30) begin
			ray.valid <= 1'b0;
			@(posedge clk);
		end
		ray.valid <= 1'b1;
		ray.origin_x <= ox; ray.origin_y <= oy; ray.origin_z <= oz;
		ray.dir_x <= dx; ray.dir_y <= dy; ray.dir_z <= dz;
		ray.t_min <= tlo; ray.t_max <= thi;
		do @(posedge clk); while (!ray.ready);
	endtask

	// ray aimed at a point near the center, mostly from the front side
	task automatic aimed_ray();
		longint p[3], d[3], o[3], t0, lim, tlo, thi;
		int     w;
		lim = (disk_r > (1 << 22)) ? (1 << 22) : disk_r;
		t0 = $urandom_range(0, 64 * ONE);
		for (int i = 0; i < 3; i++) begin
			w = $urandom_range(0, int'(lim + lim / 4));
			p[i] = longint'(disk_c[i]) + ($urandom_range(1) ? w : -w);
			d[i] = -longint'(disk_n[i]) * $urandom_range(1, 4)
				+ $signed($urandom_range(0, 8192)) - 4096;
			o[i] = p[i] - ((t0 * d[i]) >>> 16);
		end
		case ($urandom_range(3))
			0: begin tlo = t0 - 2; thi = t0 + 2; end
			1: begin tlo = 0; thi = 64 * ONE; end
			2: begin tlo = t0 + $urandom_range(1, ONE); thi = 64 * ONE; end
			default: begin tlo = $signed($urandom()); thi = $signed($urandom()); end
		endcase
		send_ray(int'(o[0]), int'(o[1]), int'(o[2]), int'(d[0]), int'(d[1]), int'(d[2]),
			int'(tlo), int'(thi));
	endtask

	task automatic noise_ray();
		send_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom());
	endtask

	task automatic random_disk(input bit raw);
		int nx, ny, nz, a;
		if (raw) begin
			set_disk($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom());
			return;
		end
		nx = 0; ny = 0; nz = 0;
		a = $urandom_range(2);
		if ($urandom_range(1)) begin
			nx = $urandom_range(0, 2 * ONE) - ONE;
			ny = $urandom_range(0, 2 * ONE) - ONE;
			nz = $urandom_range(0, 2 * ONE) - ONE;
		end else begin
			if (a == 0) nx = $urandom_range(1) ? ONE : -ONE;
			else if (a == 1) ny = $urandom_range(1) ? ONE : -ONE;
			else nz = $urandom_range(1) ? ONE : -ONE;
		end
		set_disk($urandom_range(0, 1 << 25) - (1 << 24), $urandom_range(0, 1 << 25) - (1 << 24),
			$urandom_range(0, 1 << 25) - (1 << 24), $urandom_range(0, 1 << 22),
			nx, ny, nz, $urandom_range(0, 256));
	endtask

	initial begin
		calm = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		ray.valid = 1'b0;
		ray.origin_x = '0; ray.origin_y = '0; ray.origin_z = '0;
		ray.dir_x = '0; ray.dir_y = '0; ray.dir_z = '0;
		ray.t_min = '0; ray.t_max = '0;
		disk_c = '{0, 0, 0};
		disk_r = ONE;
		disk_n = '{0, 0, ONE};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset disk: unit disk at the origin facing +z, tolerance one lsb
		send_ray(0, 0, 5 * ONE, 0, 0, -ONE, 0, 10 * ONE);            // straight hit
		send_ray(ONE / 2, ONE / 2, 2 * ONE, 0, 0, -ONE, 0, 10 * ONE); // off-center hit
		send_ray(ONE, ONE, 2 * ONE, 0, 0, -ONE, 0, 10 * ONE);         // outside radius
		send_ray(ONE, 0, 2 * ONE, 0, 0, -ONE, 0, 10 * ONE);           // on the rim
		send_ray(0, 0, 2 * ONE, ONE, 0, 0, 0, 10 * ONE);              // parallel
		send_ray(0, 0, -5 * ONE, 0, 0, ONE, -10 * ONE, 10 * ONE);     // back face
		send_ray(0, 0, 1, 0, 0, -1, -10 * ONE, 10 * ONE);             // den equals tolerance
		send_ray(0, 0, 1, 0, 0, -2, -10 * ONE, 10 * ONE);             // just above tolerance
		send_ray(0, 0, 32'h7fffffff, 0, 0, -2, 32'h80000000, 32'h7fffffff); // t out of range
		send_ray(0, 0, -3 * ONE, 0, 0, -ONE, -10 * ONE, 0);           // negative t hit
		send_ray(0, 0, 5 * ONE, 0, 0, -ONE, 10 * ONE, 0);             // empty interval
		send_ray(0, 0, 5 * ONE, 0, 0, -ONE, 5 * ONE, 5 * ONE);        // t on both bounds
		send_ray(0, 0, 5 * ONE, 0, 0, -ONE, 5 * ONE + 1, 9 * ONE);    // just below t_min
		send_ray(0, 0, 5 * ONE, 0, 0, -ONE, 0, 5 * ONE - 1);          // just above t_max
		send_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000);
		send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_ray(0, 0, 0, 0, 0, 0, 0, 0);
		send_ray(0, 0, 32'h7fffffff, 0, 0, 32'h80000000, 32'h80000000, 32'h7fffffff);

		// phases of disks, each followed by a burst of rays
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: set_disk(3 * ONE / 2, -2 * ONE, 3 * ONE, 2 * ONE, 0, 0, -ONE, 0);
				1: set_disk(0, 0, 0, 0, ONE, 0, 0, 0);                    // zero radius
				2: set_disk(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 0, ONE, 0,
					32'hffff);                                           // extreme disk
				3: set_disk(7 * ONE, -ONE, 2 * ONE, 10 * ONE, 0, -ONE, 0, 1);
				4: set_disk(0, ONE, -ONE, 5 * ONE, 32'h1ffff, 32'h20000, ONE / 2, 0);
				5, 9: random_disk(1'b1);                                 // raw register bits
				default: random_disk(1'b0);
			endcase
			calm = (ph == 3 || ph == 7);
			for (int k = 0; k < 145; k++) begin
				// hold the sender back until the pipe empties
				if (ph == 6 && k == 70) begin
					ray.valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				if ($urandom_range(99) < 75) aimed_ray();
				else noise_ray();
			end
			ray.valid <= 1'b0;
			@(posedge clk);
		end
		calm = 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
